@@ src/hamiltonian_cycle_enumerator_assert.svh @@
// ----------------------------------------------------------------------------
// hamiltonian cycle enumerator assertion macros
// shared property wrappers for the checker, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef HAMILTONIAN_CYCLE_ENUMERATOR_ASSERT_SVH
`define HAMILTONIAN_CYCLE_ENUMERATOR_ASSERT_SVH

// checked outside reset only
`define HCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked while reset is held as well
`define HCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/hce_pkg.sv @@
// ----------------------------------------------------------------------------
// hce_pkg
// shared widths, command codes, register indexes and beat types
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int VID_W        = 3;
  localparam int NV_W         = 4;
  localparam int RANK_W       = 13;
  localparam int ORD_W        = 21;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 2'd1;

  localparam logic [NV_W-1:0]  NV_RESET = 4'd6;
  localparam logic [VID_W-1:0] SV_RESET = 3'd0;

  typedef enum logic [1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_CLEAR    = 2'd1,
    CMD_FIND     = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [VID_W-1:0] vertex_a;
    logic [VID_W-1:0] vertex_b;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic              scan_done;
    logic [RANK_W-1:0] cycle_rank;
    logic [ORD_W-1:0]  cycle_order;
  } res_t;

endpackage

@@ src/hamiltonian_cycle_enumerator.sv @@
// add edge: result registered after states S_ADD_A and S_ADD_B; clear, restart,
// find when done: result in the next cycle; find walks orders, early out on a miss,
// one adjacency row read per hop through the single read port of the row memory
// worst case 5040 orders walked per find at 8 vertices; results cannot stall
// one command at a time: the next beat is taken in the cycle its result shows
// reset: graph empty via row valid bits, 6 vertices, start vertex 0, scan at rank 0
// ----------------------------------------------------------------------------
// hamiltonian_cycle_enumerator
// brute-force hamiltonian cycle search over vertex orders, adjacency in memory
// ----------------------------------------------------------------------------
module hamiltonian_cycle_enumerator #(
  parameter int MaxVertices = hce_pkg::MAX_VERTICES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hce_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            start,
  input  hce_pkg::cmd_t                   cmd_i,
  output logic                            busy,
  output logic                            res_valid_o,
  output hce_pkg::res_t                   res_o
);

  localparam int VidW   = hce_pkg::VID_W;
  localparam int NvW    = hce_pkg::NV_W;
  localparam int RankW  = hce_pkg::RANK_W;
  localparam int OrdW   = hce_pkg::ORD_W;
  localparam int OrdLen = MaxVertices - 1;
  localparam int IdxW   = (OrdLen > 1) ? $clog2(OrdLen) : 1;
  localparam int AW     = $clog2(MaxVertices);
  localparam int MW     = $clog2(MaxVertices);
  localparam int CW     = $clog2(MaxVertices + 1);

  typedef logic [OrdLen-1:0][VidW-1:0] ord_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_A,
    S_ADD_B,
    S_WALK
  } state_e;

  function automatic logic [MW-1:0] used_m(input logic [NvW-1:0] nv);
    if (nv < 4'd3) begin
      return MW'(2);
    end else if (nv > MaxVertices) begin
      return MW'(OrdLen);
    end
    return MW'(nv - 4'd1);
  endfunction

  function automatic ord_t init_order(input logic [MW-1:0] m, input logic [VidW-1:0] s);
    ord_t o;
    o = '0;
    for (int k = 0; k < OrdLen; k++) begin
      if (k < m) begin
        o[k] = (k >= s) ? VidW'(k + 1) : VidW'(k);
      end
    end
    return o;
  endfunction

  function automatic logic [RankW-1:0] fact(input logic [MW-1:0] m);
    logic [RankW-1:0] f;
    case (int'(m))
      2: f = RankW'(2);
      3: f = RankW'(6);
      4: f = RankW'(24);
      5: f = RankW'(120);
      6: f = RankW'(720);
      7: f = RankW'(5040);
      default: f = RankW'(1);
    endcase
    return f;
  endfunction

  state_e                  st_q, st_d;
  logic [NvW-1:0]          nv_q, nv_d;
  logic [VidW-1:0]         sv_q, sv_d;
  logic [RankW-1:0]        cursor_q, cursor_d;
  logic                    exh_q, exh_d;
  ord_t                    order_q, order_d, order_nxt;
  logic [CW-1:0]           c_q, c_d;
  logic [CW-1:0]           cp_q, cp_d;
  logic [CW-1:0]           cm1;
  logic                    pend_q, pend_d;
  logic                    fok_q, fok_d;
  logic [VidW-1:0]         ea_q, ea_d;
  logic [VidW-1:0]         eb_q, eb_d;
  logic                    res_valid_q, res_valid_d;
  hce_pkg::res_t           res_q, res_d;
  logic [MaxVertices-1:0]  vld_q, vld_d;
  logic                    rvld_q;

  logic [MaxVertices-1:0]  adj_mem [MaxVertices];
  logic [MaxVertices-1:0]  rdata_q;
  logic [MaxVertices-1:0]  row;
  logic                    mem_we;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           raddr;
  logic [MaxVertices-1:0]  wdata;

  logic [MW-1:0]           m;
  logic [RankW-1:0]        total;
  logic                    restart;
  logic                    acc;
  logic [VidW-1:0]         from_v;
  logic [VidW-1:0]         to_v;
  logic                    hop_ok;
  logic                    adv_last;
  logic [OrdW-1:0]         ord_bits;

  hce_next_perm #(
    .MaxVertices(MaxVertices)
  ) u_next_perm (
    .order_i(order_q),
    .m_i    (m),
    .next_o (order_nxt)
  );

  assign m           = used_m(nv_q);
  assign total       = fact(m);
  assign busy        = (st_q != S_IDLE);
  assign acc         = start && !busy;
  assign row         = rvld_q ? rdata_q : '0;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign cm1      = c_q - 1'b1;
  assign from_v   = (c_q == '0) ? sv_q : order_q[cm1[IdxW-1:0]];
  assign to_v     = (cp_q == CW'(m)) ? sv_q : order_q[cp_q[IdxW-1:0]];
  assign hop_ok   = fok_q && (to_v < MaxVertices) && row[to_v[AW-1:0]];
  assign adv_last = ({1'b0, cursor_q} + 1'b1) >= {1'b0, total};

  always_comb begin
    ord_bits = '0;
    for (int k = 0; k < OrdLen; k++) begin
      if (k < m) begin
        ord_bits[VidW*k +: VidW] = order_q[k];
      end
    end
  end

  always_comb begin
    st_d        = st_q;
    nv_d        = nv_q;
    sv_d        = sv_q;
    cursor_d    = cursor_q;
    exh_d       = exh_q;
    order_d     = order_q;
    c_d         = c_q;
    cp_d        = cp_q;
    pend_d      = pend_q;
    fok_d       = fok_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    vld_d       = vld_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    restart     = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        hce_pkg::CFG_NUM_VERTICES: begin
          nv_d    = cfg_wdata_i;
          restart = 1'b1;
        end
        hce_pkg::CFG_START_VERTEX: begin
          sv_d    = cfg_wdata_i[VidW-1:0];
          restart = 1'b1;
        end
        default: ;
      endcase
    end

    case (st_q)
      S_IDLE: begin
        if (acc) begin
          res_valid_d     = 1'b1;
          res_d           = '0;
          res_d.scan_done = exh_q;
          case (cmd_i.cmd)
            hce_pkg::CMD_ADD_EDGE: begin
              if (cmd_i.vertex_a < MaxVertices && cmd_i.vertex_b < MaxVertices) begin
                res_valid_d = 1'b0;
                raddr       = cmd_i.vertex_a[AW-1:0];
                ea_d        = cmd_i.vertex_a;
                eb_d        = cmd_i.vertex_b;
                st_d        = S_ADD_A;
              end
            end
            hce_pkg::CMD_CLEAR: begin
              vld_d = '0;
            end
            hce_pkg::CMD_RESTART: begin
              restart         = 1'b1;
              res_d.scan_done = 1'b0;
            end
            hce_pkg::CMD_FIND: begin
              if (!exh_q) begin
                res_valid_d = 1'b0;
                c_d         = '0;
                pend_d      = 1'b0;
                st_d        = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADD_A: begin
        // row b is read while row a is written: equal rows give the same value
        mem_we                       = 1'b1;
        waddr                        = ea_q[AW-1:0];
        wdata                        = row;
        wdata[eb_q[AW-1:0]]          = 1'b1;
        vld_d[ea_q[AW-1:0]]          = 1'b1;
        raddr                        = eb_q[AW-1:0];
        st_d                         = S_ADD_B;
      end
      S_ADD_B: begin
        mem_we                       = 1'b1;
        waddr                        = eb_q[AW-1:0];
        wdata                        = row;
        wdata[ea_q[AW-1:0]]          = 1'b1;
        vld_d[eb_q[AW-1:0]]          = 1'b1;
        res_valid_d                  = 1'b1;
        res_d                        = '0;
        res_d.scan_done              = exh_q;
        st_d                         = S_IDLE;
      end
      S_WALK: begin
        pend_d = 1'b0;
        if (c_q <= CW'(m)) begin
          raddr  = from_v[AW-1:0];
          fok_d  = (from_v < MaxVertices);
          cp_d   = c_q;
          pend_d = 1'b1;
          c_d    = c_q + 1'b1;
        end
        if (pend_q && (!hop_ok || cp_q == CW'(m))) begin
          // order settled: drop the read in flight and step on
          c_d    = '0;
          pend_d = 1'b0;
          if (adv_last) begin
            exh_d    = 1'b1;
            cursor_d = total;
          end else begin
            cursor_d = cursor_q + 1'b1;
            order_d  = order_nxt;
          end
          if (hop_ok) begin
            res_valid_d       = 1'b1;
            res_d             = '0;
            res_d.found       = 1'b1;
            res_d.scan_done   = adv_last;
            res_d.cycle_rank  = cursor_q;
            res_d.cycle_order = ord_bits;
            st_d              = S_IDLE;
          end else if (adv_last) begin
            res_valid_d     = 1'b1;
            res_d           = '0;
            res_d.scan_done = 1'b1;
            st_d            = S_IDLE;
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase

    if (restart) begin
      order_d  = init_order(used_m(nv_d), sv_d);
      cursor_d = '0;
      exh_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      nv_q        <= hce_pkg::NV_RESET;
      sv_q        <= hce_pkg::SV_RESET;
      cursor_q    <= '0;
      exh_q       <= 1'b0;
      order_q     <= init_order(used_m(hce_pkg::NV_RESET), hce_pkg::SV_RESET);
      c_q         <= '0;
      cp_q        <= '0;
      pend_q      <= 1'b0;
      fok_q       <= 1'b0;
      ea_q        <= '0;
      eb_q        <= '0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      st_q        <= st_d;
      nv_q        <= nv_d;
      sv_q        <= sv_d;
      cursor_q    <= cursor_d;
      exh_q       <= exh_d;
      order_q     <= order_d;
      c_q         <= c_d;
      cp_q        <= cp_d;
      pend_q      <= pend_d;
      fok_q       <= fok_d;
      ea_q        <= ea_d;
      eb_q        <= eb_d;
      vld_q       <= vld_d;
      rvld_q      <= vld_q[raddr];
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      adj_mem[waddr] <= wdata;
    end
    rdata_q <= adj_mem[raddr];
  end

endmodule

@@ src/hce_next_perm.sv @@
// ----------------------------------------------------------------------------
// hce_next_perm
// next lexicographic order of the first m entries of the vertex list
// ----------------------------------------------------------------------------
module hce_next_perm #(
  parameter int MaxVertices = hce_pkg::MAX_VERTICES
) (
  input  logic [MaxVertices-2:0][hce_pkg::VID_W-1:0] order_i,
  input  logic [$clog2(MaxVertices)-1:0]              m_i,
  output logic [MaxVertices-2:0][hce_pkg::VID_W-1:0] next_o
);

  localparam int VidW   = hce_pkg::VID_W;
  localparam int OrdLen = MaxVertices - 1;
  localparam int IdxW   = (OrdLen > 1) ? $clog2(OrdLen) : 1;

  logic [IdxW-1:0]              piv;
  logic [IdxW-1:0]              pm1;
  logic [IdxW-1:0]              sj;
  logic [IdxW-1:0]              ri;
  logic [VidW-1:0]              pval;
  logic [OrdLen-1:0][VidW-1:0]  swp;

  always_comb begin
    piv = '0;
    for (int k = 1; k < OrdLen; k++) begin
      if (k < m_i && order_i[k-1] < order_i[k]) begin
        piv = IdxW'(k);
      end
    end
    pm1  = piv - 1'b1;
    pval = order_i[pm1];
    sj   = pm1;
    for (int k = 0; k < OrdLen; k++) begin
      if (k >= piv && k < m_i && order_i[k] > pval) begin
        sj = IdxW'(k);
      end
    end
    swp      = order_i;
    swp[pm1] = order_i[sj];
    swp[sj]  = pval;
    next_o   = swp;
    ri       = '0;
    // reverse the tail behind the pivot
    for (int k = 0; k < OrdLen; k++) begin
      if (k >= piv && k < m_i) begin
        ri        = IdxW'(int'(m_i) - 1 + int'(piv) - k);
        next_o[k] = swp[ri];
      end
    end
  end

endmodule

@@ src/hce_checker.sv @@
// ----------------------------------------------------------------------------
// hce_checker
// port-level checks on command beats and result beats of the enumerator
// ----------------------------------------------------------------------------
`include "hamiltonian_cycle_enumerator_assert.svh"

module hce_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input hce_pkg::cmd_t cmd_i,
  input logic          busy_i,
  input logic          res_valid_i,
  input hce_pkg::res_t res_i
);

  `HCE_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !res_valid_i && !busy_i, "beat during reset")
  `HCE_ASSERT(a_short_cmd_result, start_i && !busy_i && (cmd_i.cmd == hce_pkg::CMD_CLEAR || cmd_i.cmd == hce_pkg::CMD_RESTART) |=> res_valid_i && !res_i.found, "clear or restart gave no result")
  `HCE_ASSERT(a_miss_is_zero, res_valid_i && !res_i.found |-> res_i.cycle_rank == '0 && res_i.cycle_order == '0, "payload on a miss")
  `HCE_ASSERT(a_hit_has_order, res_valid_i && res_i.found |-> res_i.cycle_order != '0, "hit with empty order")
  `HCE_ASSERT(a_result_when_idle, res_valid_i |-> !busy_i, "result while still searching")

endmodule

bind hamiltonian_cycle_enumerator hce_checker u_hce_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start),
  .cmd_i      (cmd_i),
  .busy_i     (busy),
  .res_valid_i(res_valid_o),
  .res_i      (res_o)
);
